### design/plti_pkg.sv
// ----------------------------------------------------------------------------
// plti_pkg
// Shared types and codes for the piecewise-linear table interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;

	localparam int PC_W = 7;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INTERP     = 3'd0,
		ST_LOW        = 3'd1,
		ST_HIGH       = 3'd2,
		ST_ZERO_WIDTH = 3'd3,
		ST_NO_SEGMENT = 3'd4
	} status_t;

	typedef struct packed {
		logic query;
		logic load;
	} op_t;

endpackage
// ----------------------------------------------------------------------------

### design/plti_front.sv
// ----------------------------------------------------------------------------
// plti_front
// Accepts items, decodes them into load/query ops and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module plti_front #(
	parameter int TABLE_DEPTH = 64,
	parameter int VALUE_WIDTH = 32,
	localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   cmd,
	input  logic [IDX_W-1:0]       entry_index,
	input  logic [VALUE_WIDTH-1:0] x_value,
	input  logic [VALUE_WIDTH-1:0] y_value,
	output logic                   q_valid,
	input  logic                   q_ready,
	output plti_pkg::op_t          q_op,
	output logic [IDX_W-1:0]       q_idx,
	output logic [VALUE_WIDTH-1:0] q_x,
	output logic [VALUE_WIDTH-1:0] q_y
);

	plti_pkg::op_t          op_q  [2];
	logic [IDX_W-1:0]       idx_q [2];
	logic [VALUE_WIDTH-1:0] x_q   [2];
	logic [VALUE_WIDTH-1:0] y_q   [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             cnt_q;
	plti_pkg::op_t          op_in;
	logic                   push;
	logic                   pop;

	always_comb begin
		op_in.query = (cmd == plti_pkg::CMD_QUERY);
		op_in.load  = (cmd == plti_pkg::CMD_LOAD) &&
			({1'b0, entry_index} < (IDX_W + 1)'(TABLE_DEPTH));
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;

	assign q_op  = op_q[rd_ptr_q];
	assign q_idx = idx_q[rd_ptr_q];
	assign q_x   = x_q[rd_ptr_q];
	assign q_y   = y_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]  <= op_in;
			idx_q[wr_ptr_q] <= entry_index;
			x_q[wr_ptr_q]   <= x_value;
			y_q[wr_ptr_q]   <= y_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
// ----------------------------------------------------------------------------

### design/plti_back.sv
// ----------------------------------------------------------------------------
// plti_back
// Table memories, breakpoint scan, bit-serial multiply-divide and the
// result register.
// ----------------------------------------------------------------------------
module plti_back #(
	parameter int TABLE_DEPTH = 64,
	parameter int VALUE_WIDTH = 32,
	localparam int IDX_W = $clog2(TABLE_DEPTH),
	localparam int NW    = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [NW-1:0]                 n_eff,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  plti_pkg::op_t                 q_op,
	input  logic [IDX_W-1:0]              q_idx,
	input  logic [VALUE_WIDTH-1:0]        q_x,
	input  logic [VALUE_WIDTH-1:0]        q_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [VALUE_WIDTH-1:0] y_result,
	output logic [IDX_W-1:0]              segment_index,
	output logic [2:0]                    status
);

	localparam int VW = VALUE_WIDTH;
	localparam int BW = $clog2(VW);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_ENDS = 7'b0000010,
		S_SCAN = 7'b0000100,
		S_PREP = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_FIN  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	logic signed [VW-1:0] x_mem [TABLE_DEPTH];
	logic signed [VW-1:0] y_mem [TABLE_DEPTH];

	state_t               state_q;
	logic [IDX_W-1:0]     ra;
	logic [IDX_W-1:0]     rb;
	logic signed [VW-1:0] xa_q, xb_q, ya_q, yb_q;
	logic signed [VW-1:0] t_q;
	logic [NW-1:0]        n_q;
	logic [NW-1:0]        i_q;
	logic [NW-1:0]        ip1;
	logic signed [VW-1:0] x0_q, x1_q, y0_q, y1_q;
	logic [VW-1:0]        a_q, b_q, d_q, r_q, quo_q;
	logic                 neg_q;
	logic [BW-1:0]        bit_q;
	logic signed [VW-1:0] res_q;
	logic [IDX_W-1:0]     seg_q;
	plti_pkg::status_t    st_q;
	logic                 out_valid_q;
	logic signed [VW-1:0] y_result_q;
	logic [IDX_W-1:0]     seg_out_q;
	plti_pkg::status_t    st_out_q;

	logic                 mem_we;
	logic signed [VW:0]   dy;
	logic [VW:0]          dy_mag;
	logic [VW+1:0]        sum, d1, d2, r_next;
	logic                 ge1, ge2;
	logic [1:0]           digit;
	logic signed [VW+1:0] y0e, qe, fin_sum;
	logic signed [VW+1:0] sat_hi, sat_lo;
	logic signed [VW-1:0] fin_res;
	logic                 out_free;

	assign q_ready  = (state_q == S_IDLE);
	assign mem_we   = q_valid && q_ready && q_op.load;
	assign ip1      = i_q + NW'(1);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		ra = '0;
		rb = '0;
		unique case (state_q)
			S_IDLE:  rb = IDX_W'(n_eff - NW'(1));
			S_ENDS:  rb = IDX_W'(1);
			S_SCAN: begin
				ra = IDX_W'(i_q + NW'(1));
				rb = IDX_W'(i_q + NW'(2));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			x_mem[q_idx] <= q_x;
			y_mem[q_idx] <= q_y;
		end
		xa_q <= x_mem[ra];
		xb_q <= x_mem[rb];
		ya_q <= y_mem[ra];
		yb_q <= y_mem[rb];
	end

	// one multiply-divide bit: r = 2r + (b ? a : 0), then reduce by d or 2d
	always_comb begin
		d1     = (VW + 2)'(d_q);
		d2     = (VW + 2)'({d_q, 1'b0});
		sum    = (VW + 2)'({r_q, 1'b0}) + (b_q[bit_q] ? (VW + 2)'(a_q) : '0);
		ge2    = (sum >= d2);
		ge1    = (sum >= d1);
		priority if (ge2) r_next = sum - d2;
		else if (ge1)     r_next = sum - d1;
		else              r_next = sum;
		digit  = ge2 ? 2'd2 : (ge1 ? 2'd1 : 2'd0);
	end

	always_comb begin
		dy      = (VW + 1)'(y1_q) - (VW + 1)'(y0_q);
		dy_mag  = dy[VW] ? (VW + 1)'(-dy) : (VW + 1)'(dy);
		y0e     = (VW + 2)'(y0_q);
		qe      = signed'((VW + 2)'(quo_q));
		fin_sum = neg_q ? (y0e - qe) : (y0e + qe);
		sat_hi  = signed'((VW + 2)'({1'b0, {(VW - 1){1'b1}}}));
		sat_lo  = -sat_hi - (VW + 2)'(1);
		priority if (fin_sum > sat_hi) fin_res = sat_hi[VW-1:0];
		else if (fin_sum < sat_lo)     fin_res = sat_lo[VW-1:0];
		else                           fin_res = fin_sum[VW-1:0];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				t_q <= q_x;
			end
			S_ENDS: begin
				if (t_q < xa_q) begin
					res_q <= ya_q;
					seg_q <= '0;
					st_q  <= plti_pkg::ST_LOW;
				end else if (t_q > xb_q) begin
					res_q <= yb_q;
					seg_q <= IDX_W'(n_q - NW'(1));
					st_q  <= plti_pkg::ST_HIGH;
				end
			end
			S_SCAN: begin
				if (ip1 >= n_q) begin
					res_q <= '0;
					seg_q <= '0;
					st_q  <= plti_pkg::ST_NO_SEGMENT;
				end else begin
					x0_q  <= xa_q;
					x1_q  <= xb_q;
					y0_q  <= ya_q;
					y1_q  <= yb_q;
					seg_q <= IDX_W'(i_q);
				end
			end
			S_PREP: begin
				res_q <= y0_q;
				st_q  <= plti_pkg::ST_ZERO_WIDTH;
				a_q   <= VW'(t_q - x0_q);
				d_q   <= VW'(x1_q - x0_q);
				b_q   <= dy_mag[VW-1:0];
				neg_q <= dy[VW];
				r_q   <= '0;
				quo_q <= '0;
			end
			S_DIV: begin
				r_q   <= r_next[VW-1:0];
				quo_q <= VW'({quo_q, 1'b0}) + VW'(digit);
			end
			S_FIN: begin
				res_q <= fin_res;
				st_q  <= plti_pkg::ST_INTERP;
			end
			S_OUT: begin
				if (out_free) begin
					y_result_q <= res_q;
					seg_out_q  <= seg_q;
					st_out_q   <= st_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			i_q         <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) out_valid_q <= 1'b1;
			else if (out_ready)                 out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid && q_op.query) begin
						n_q     <= n_eff;
						state_q <= S_ENDS;
					end
				end
				S_ENDS: begin
					i_q <= '0;
					if ((t_q < xa_q) || (t_q > xb_q)) state_q <= S_OUT;
					else                              state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (ip1 >= n_q)                          state_q <= S_OUT;
					else if ((xa_q <= t_q) && (xb_q >= t_q)) state_q <= S_PREP;
					else                                     i_q     <= ip1;
				end
				S_PREP: begin
					bit_q <= BW'(VW - 1);
					if (x1_q == x0_q) state_q <= S_OUT;
					else              state_q <= S_DIV;
				end
				S_DIV: begin
					if (bit_q == '0) state_q <= S_FIN;
					else             bit_q   <= bit_q - BW'(1);
				end
				S_FIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign y_result      = y_result_q;
	assign segment_index = seg_out_q;
	assign status        = st_out_q;

endmodule
// ----------------------------------------------------------------------------

### design/piecewise_linear_table_interp.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// Breakpoint table with clamped piecewise-linear lookup in signed Q16.16.
//
//   channel  signals                                      moves
//   in       in_valid/in_ready, cmd, entry_index,         one load or query
//            x_value, y_value
//   out      out_valid/out_ready, y_result,               one result per query
//            segment_index, status
//   cfg      cfg_wr_en, cfg_wr_data                       point_count write
//
// A load is written to the table when the back end takes it from the queue. An
// interpolated query holds the back end until its result is registered: it
// scans the segments in order, then computes the quotient one bit at a time.
// Clamped queries go from the end-point check straight to the result; a
// zero-width segment skips the division, and a missing segment ends the scan.
// Reset clears control and sets point_count to 2; table contents are
// undefined until loaded. A held result stalls the back end; the two-entry
// queue keeps taking transfers until it is full.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp #(
	parameter int TABLE_DEPTH = 64,
	parameter int VALUE_WIDTH = 32,
	localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [plti_pkg::PC_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [IDX_W-1:0]              entry_index,
	input  logic signed [VALUE_WIDTH-1:0] x_value,
	input  logic signed [VALUE_WIDTH-1:0] y_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [VALUE_WIDTH-1:0] y_result,
	output logic [IDX_W-1:0]              segment_index,
	output logic [2:0]                    status
);

	localparam int NW = $clog2(TABLE_DEPTH + 1);
	localparam int CW = (NW > plti_pkg::PC_W) ? NW : plti_pkg::PC_W;

	logic [plti_pkg::PC_W-1:0] point_count_q;
	logic [NW-1:0]             n_eff;
	logic                      q_valid;
	logic                      q_ready;
	plti_pkg::op_t             q_op;
	logic [IDX_W-1:0]          q_idx;
	logic [VALUE_WIDTH-1:0]    q_x;
	logic [VALUE_WIDTH-1:0]    q_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= plti_pkg::PC_W'(2);
		end else if (cfg_wr_en) begin
			point_count_q <= cfg_wr_data;
		end
	end

	always_comb begin
		priority if (point_count_q == '0)
			n_eff = NW'(1);
		else if (CW'(point_count_q) > CW'(TABLE_DEPTH))
			n_eff = NW'(TABLE_DEPTH);
		else
			n_eff = NW'(point_count_q);
	end

	plti_front #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.entry_index (entry_index),
		.x_value     (x_value),
		.y_value     (y_value),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_op        (q_op),
		.q_idx       (q_idx),
		.q_x         (q_x),
		.q_y         (q_y)
	);

	plti_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.n_eff         (n_eff),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_op          (q_op),
		.q_idx         (q_idx),
		.q_x           (q_x),
		.q_y           (q_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.y_result      (y_result),
		.segment_index (segment_index),
		.status        (status)
	);

	a_seg_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == plti_pkg::ST_INTERP || status == plti_pkg::ST_ZERO_WIDTH)
		|-> ((NW + 1)'(segment_index) + (NW + 1)'(1)) < (NW + 1)'(n_eff))
		else $error("segment index beyond breakpoints in use");

	a_no_seg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == plti_pkg::ST_NO_SEGMENT)
		|-> (y_result == '0) && (segment_index == '0))
		else $error("missing-segment result not zeroed");

	a_low_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == plti_pkg::ST_LOW) |-> (segment_index == '0))
		else $error("low clamp not at first breakpoint");

endmodule
// ----------------------------------------------------------------------------
